// File: rtl/core/mlc_pkg.sv
// Shared types, register indexes and reset values for the motion and light LED controller.
package mlc_pkg;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MOTION_COOLDOWN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPDATE_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_DEBOUNCE    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLASH_IGNORE    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DARK_THRESHOLD  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIGHT_INTERVAL  = 3'd5;

   localparam int TIME_WIDTH   = 32;
   localparam int SAMPLE_WIDTH = 12;
   localparam int REQ_WIDTH    = 48;
   localparam int RSP_WIDTH    = 8;

   // Register reset values.
   localparam logic [TIME_WIDTH-1:0]   RST_MOTION_COOLDOWN = 32'd5000;
   localparam logic [TIME_WIDTH-1:0]   RST_UPDATE_INTERVAL = 32'd500;
   localparam logic [TIME_WIDTH-1:0]   RST_END_DEBOUNCE    = 32'd200;
   localparam logic [TIME_WIDTH-1:0]   RST_FLASH_IGNORE    = 32'd10000;
   localparam logic [SAMPLE_WIDTH-1:0] RST_DARK_THRESHOLD  = 12'd2000;
   localparam logic [TIME_WIDTH-1:0]   RST_LIGHT_INTERVAL  = 32'd1000;

   typedef logic [TIME_WIDTH-1:0] time_ms_type;

   // Configuration registers.
   typedef struct packed {
      time_ms_type             motion_cooldown_ms;
      time_ms_type             update_interval_ms;
      time_ms_type             end_debounce_ms;
      time_ms_type             flash_ignore_ms;
      logic [SAMPLE_WIDTH-1:0] dark_threshold;
      time_ms_type             light_interval_ms;
   } cfg_type;

   // One poll, laid out as on the request tdata (now_ms in the lowest bits).
   typedef struct packed {
      logic                    cooldown_clear;
      logic                    system_ready;
      logic                    security_active;
      logic [SAMPLE_WIDTH-1:0] light_sample;
      logic                    pir_level;
      time_ms_type             now_ms;
   } item_type;

   // One result, laid out as on the response tdata (ir_led_on in bit 0).
   typedef struct packed {
      logic motion_end_event;
      logic motion_update_event;
      logic motion_start_event;
      logic dark_now;
      logic flash_led_on;
      logic ir_led_on;
   } result_type;

   // Controller state carried from poll to poll.
   typedef struct packed {
      logic        pir_latched;
      logic        motion_active;
      time_ms_type last_start_time;
      time_ms_type last_update_time;
      time_ms_type end_candidate_time;
      logic        end_candidate_valid;
      time_ms_type ignore_until_time;
      logic        ignore_valid;
      time_ms_type last_light_time;
      logic        dark_flag;
      logic        ir_led_state;
      logic        flash_led_state;
   } state_type;

   // Sets both LEDs from darkness and motion; a flash turn-on opens the ignore window, a turn-off closes it.
   function automatic state_type drive_leds(state_type s, time_ms_type now,
                                            time_ms_type flash_ignore);
      state_type r;
      logic      want_flash;
      r          = s;
      want_flash = s.dark_flag & s.motion_active;
      r.ir_led_state = s.dark_flag & ~s.motion_active;
      if (want_flash != s.flash_led_state) begin
         r.flash_led_state = want_flash;
         if (want_flash) begin
            r.ignore_until_time = now + flash_ignore;
            r.ignore_valid      = 1'b1;
         end else begin
            r.ignore_until_time = '0;
            r.ignore_valid      = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

// File: rtl/core/mlc_step.sv
// Next-state and result logic for one poll: cooldown clear, motion step, then light step.
module mlc_step (
   input  mlc_pkg::cfg_type    cfg,
   input  mlc_pkg::state_type  state_cur,
   input  mlc_pkg::item_type   item,
   output mlc_pkg::state_type  state_nxt,
   output mlc_pkg::result_type result
);
   import mlc_pkg::*;

   always_comb begin
      state_type   s;
      time_ms_type now;
      logic        ev_start;
      logic        ev_update;
      logic        ev_end;
      logic        dark;

      s         = state_cur;
      now       = item.now_ms;
      ev_start  = 1'b0;
      ev_update = 1'b0;
      ev_end    = 1'b0;
      dark      = 1'b0;

      // The cooldown clear takes effect even when the system is not ready.
      if (item.cooldown_clear) begin
         s.last_start_time = '0;
      end

      if (item.system_ready) begin
         // Motion step.
         if (item.pir_level && !s.pir_latched) begin
            if ((now - s.last_start_time) > cfg.motion_cooldown_ms) begin
               s.last_start_time     = now;
               s.pir_latched         = 1'b1;
               s.motion_active       = 1'b1;
               s.last_update_time    = now;
               s.end_candidate_valid = 1'b0;
               s                     = drive_leds(s, now, cfg.flash_ignore_ms);
               ev_start              = 1'b1;
            end else begin
               s.pir_latched         = 1'b1;
               s.end_candidate_valid = 1'b0;
            end
         end else if (item.pir_level && s.pir_latched) begin
            if ((now - s.last_update_time) >= cfg.update_interval_ms) begin
               s.last_update_time = now;
               ev_update          = item.security_active;
            end
            s.end_candidate_valid = 1'b0;
         end else if (!item.pir_level && s.pir_latched) begin
            if (!s.end_candidate_valid) begin
               s.end_candidate_time  = now;
               s.end_candidate_valid = 1'b1;
            end else if ((now - s.end_candidate_time) >= cfg.end_debounce_ms) begin
               s.pir_latched         = 1'b0;
               s.motion_active       = 1'b0;
               s.end_candidate_valid = 1'b0;
               s                     = drive_leds(s, now, cfg.flash_ignore_ms);
               ev_end                = 1'b1;
            end
         end else begin
            s.end_candidate_valid = 1'b0;
         end

         // Light step; the ignore window may have been opened by the motion step above.
         if ((now - s.last_light_time) >= cfg.light_interval_ms) begin
            s.last_light_time = now;
            if (!(s.ignore_valid && (now < s.ignore_until_time))) begin
               dark = item.light_sample < cfg.dark_threshold;
               if (dark != s.dark_flag) begin
                  s.dark_flag = dark;
                  s           = drive_leds(s, now, cfg.flash_ignore_ms);
               end
            end
         end
      end

      state_nxt                  = s;
      result.ir_led_on           = s.ir_led_state;
      result.flash_led_on        = s.flash_led_state;
      result.dark_now            = s.dark_flag;
      result.motion_start_event  = ev_start;
      result.motion_update_event = ev_update;
      result.motion_end_event    = ev_end;
   end

endmodule

// File: rtl/core/motion_light_led_controller.sv
// Top level of the motion and light LED controller.
//
// Each request transfer carries one poll: timestamp, PIR level, light sample and
// status flags. Each poll produces exactly one response transfer with the LED
// levels, the darkness decision and the motion event pulses for that poll.
// Registers are written through the csr_ channel, which is always ready; write
// them only while no poll is in flight.
//
// A poll is captured in an input register, processed combinationally by the step
// logic (a few 32-bit subtract-and-compare operations) and lands in the result
// register, which drives rsp_tvalid and rsp_tdata. Throughput is one poll per
// cycle while rsp_tready stays high. When the receiver stalls, the result
// register holds its value and the input register keeps one poll waiting;
// req_tready drops only when both are full and rsp_tready is low.
// Reset clears all controller state, empties both registers and loads the
// register reset values.
module motion_light_led_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata, lowest bit up: now_ms[31:0], pir_level, light_sample[11:0],
   // security_active, system_ready, cooldown_clear.
   input  logic [mlc_pkg::REQ_WIDTH-1:0]         req_tdata,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata, lowest bit up: ir_led_on, flash_led_on, dark_now,
   // motion_start_event, motion_update_event, motion_end_event, two zero bits.
   output logic [mlc_pkg::RSP_WIDTH-1:0]         rsp_tdata,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mlc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mlc_pkg::TIME_WIDTH-1:0]        csr_data
);
   import mlc_pkg::*;

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       item_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       advance;

   // A poll moves into the result register when it is empty or being drained.
   assign advance    = item_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~item_valid_ff | advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_WIDTH - $bits(result_type)){1'b0}}, result_ff};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_cooldown_ms <= RST_MOTION_COOLDOWN;
         cfg_ff.update_interval_ms <= RST_UPDATE_INTERVAL;
         cfg_ff.end_debounce_ms    <= RST_END_DEBOUNCE;
         cfg_ff.flash_ignore_ms    <= RST_FLASH_IGNORE;
         cfg_ff.dark_threshold     <= RST_DARK_THRESHOLD;
         cfg_ff.light_interval_ms  <= RST_LIGHT_INTERVAL;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MOTION_COOLDOWN: cfg_ff.motion_cooldown_ms <= csr_data;
            CSR_UPDATE_INTERVAL: cfg_ff.update_interval_ms <= csr_data;
            CSR_END_DEBOUNCE:    cfg_ff.end_debounce_ms    <= csr_data;
            CSR_FLASH_IGNORE:    cfg_ff.flash_ignore_ms    <= csr_data;
            CSR_DARK_THRESHOLD:  cfg_ff.dark_threshold     <= csr_data[SAMPLE_WIDTH-1:0];
            CSR_LIGHT_INTERVAL:  cfg_ff.light_interval_ms  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_type'(req_tdata);
      end
   end

   // Per-poll step logic.
   mlc_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // Controller state, updated once per processed poll.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

endmodule
